FILE: rtl/tsf_pkg.sv
package tsf_pkg;

    localparam int MaxPattern = 127;
    localparam int MaxBytes   = 1024;

    localparam int PatW = $clog2(MaxPattern + 1);
    localparam int PosW = $clog2(MaxBytes + 1);
    localparam int IdxW = 7;

    localparam int MinPattern = 4;
    localparam int MatchStart = 32;
    localparam int MinSegment = 43;

    localparam logic [7:0] RecHandshake  = 8'h16;
    localparam logic [7:0] HsClientHello = 8'h01;
    localparam logic [7:0] VerMajor      = 8'h03;
    localparam logic [7:0] VerMinor      = 8'h01;

    typedef enum logic {
        CmdPattern = 1'b0,
        CmdSegment = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        VerdictAccept   = 3'd0,
        VerdictShort    = 3'd1,
        VerdictNotTls   = 3'd2,
        VerdictOldVer   = 3'd3,
        VerdictNotHello = 3'd4,
        VerdictNoMatch  = 3'd5
    } t_verdict;

    typedef struct packed {
        t_cmd            cmd;
        logic [IdxW-1:0] pattern_index;
        logic [7:0]      byte_value;
        logic            last_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]      verdict;
        logic [PosW-1:0] accepted_length;
    } t_out_word;

    // matcher control for one processed word
    typedef struct packed {
        logic            take;
        logic            pat_wr;
        logic [IdxW-1:0] pat_index;
        logic [7:0]      data;
    } t_mstep;

    // segment tracker control for one processed word
    typedef struct packed {
        logic seg;
        logic last;
    } t_seg_ctl;

endpackage

FILE: rtl/tls_hello_sni_filter_unit.sv
// TLS ClientHello host-name filter. Load the pattern with cmd=0 words (one byte
// each at pattern_index), set pattern_len over the config channel (values below
// 4 act as 4), then stream the first segment of a connection with cmd=1 words.
// A word marked last_byte yields one verdict word: accept, too short (< 43
// bytes), record type not 0x16, version below 3.1, not ClientHello, or no
// match, checked in that order; accepted_length carries the byte count on
// accept. The pattern only matches if it starts at offset 32 or later and lies
// wholly inside the segment. Bytes past 1024 are dropped. Throughput is one
// word per cycle, with no dead cycles between segments; the input stalls only
// while a verdict word waits in a stalled result register. A verdict word passes
// through the input register, then the result register. The cycle is set by
// the 127-lane window compare behind a byte barrel shift of the pattern store.
// Pattern entries never written read as undefined.
module tls_hello_sni_filter_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    // input word channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  tsf_pkg::t_in_word          i_in_word,

    // result word channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output tsf_pkg::t_out_word         o_out_word,

    // config: pattern_len
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tsf_pkg::PatW-1:0]   i_cfg_data
);
    import tsf_pkg::*;

    // config register
    logic [PatW-1:0] r_plen;
    logic [PatW-1:0] plen_act;

    // input stage
    logic            r_in_valid;
    t_in_word        r_in;

    // result stage
    logic            r_out_valid;
    t_out_word       r_out;

    logic            is_seg;
    logic            makes_result;
    logic            out_free;
    logic            proc;
    logic            in_take;

    t_mstep          mstep;
    t_seg_ctl        seg_ctl;
    logic            take;
    logic            hit;
    t_out_word       result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= PatW'(MinPattern);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_plen <= i_cfg_data;
        end
    end

    // clamp into the supported pattern length range
    always_comb begin
        priority if (r_plen < PatW'(MinPattern)) begin
            plen_act = PatW'(MinPattern);
        end else if (int'(r_plen) > MaxPattern) begin
            plen_act = PatW'(MaxPattern);
        end else begin
            plen_act = r_plen;
        end
    end

    // Flow control: the held word retires unless it would produce a verdict
    // and the result register is full and stalled.
    assign is_seg       = (r_in.cmd == CmdSegment);
    assign makes_result = is_seg && r_in.last_byte;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign proc         = r_in_valid && (!makes_result || out_free);
    assign o_in_stall   = r_in_valid && !proc;
    assign in_take      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
            r_in       <= i_in_word;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    // pattern writes and window shifts
    assign mstep.take      = take;
    assign mstep.pat_wr    = proc && !is_seg;
    assign mstep.pat_index = r_in.pattern_index;
    assign mstep.data      = r_in.byte_value;

    tsf_matcher u_matcher (
        .i_clk  (i_clk),
        .i_step (mstep),
        .i_plen (plen_act),
        .o_hit  (hit)
    );

    // byte count, header capture, sticky match, verdict
    assign seg_ctl.seg  = proc && is_seg;
    assign seg_ctl.last = r_in.last_byte;

    tsf_seg_track u_seg_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (seg_ctl),
        .i_byte   (r_in.byte_value),
        .i_plen   (plen_act),
        .i_hit    (hit),
        .o_take   (take),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && makes_result) begin
            r_out_valid <= 1'b1;
            r_out       <= result;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

FILE: rtl/tsf_matcher.sv
module tsf_matcher (
    input  logic                      i_clk,
    input  tsf_pkg::t_mstep           i_step,
    input  logic [tsf_pkg::PatW-1:0]  i_plen,
    output logic                      o_hit
);
    import tsf_pkg::*;

    logic [7:0]              r_pattern [MaxPattern];
    logic [7:0]              r_window  [MaxPattern];
    logic [7:0]              n_window  [MaxPattern];
    logic [MaxPattern*8-1:0] rev_pat;
    logic [MaxPattern*8-1:0] aligned;
    logic [PatW-1:0]         shamt;
    logic [MaxPattern-1:0]   lane_ok;

    always_ff @(posedge i_clk) begin
        if (i_step.pat_wr && (int'(i_step.pat_index) < MaxPattern)) begin
            r_pattern[i_step.pat_index[PatW-1:0]] <= i_step.data;
        end
        if (i_step.take) begin
            for (int k = 0; k < MaxPattern; k++) begin
                r_window[k] <= n_window[k];
            end
        end
    end

    // window with the incoming byte already shifted in; lane 0 is newest
    always_comb begin
        n_window[0] = i_step.data;
        for (int k = 1; k < MaxPattern; k++) begin
            n_window[k] = r_window[k-1];
        end
    end

    // lane k must equal pattern[n-1-k]: reverse the pattern, shift by (Max - n)
    always_comb begin
        for (int i = 0; i < MaxPattern; i++) begin
            rev_pat[(MaxPattern-1-i)*8 +: 8] = r_pattern[i];
        end
        shamt   = PatW'(MaxPattern) - i_plen;
        aligned = rev_pat >> {shamt, 3'b000};
        for (int k = 0; k < MaxPattern; k++) begin
            lane_ok[k] = (PatW'(k) >= i_plen) || (n_window[k] == aligned[k*8 +: 8]);
        end
    end

    assign o_hit = &lane_ok;

endmodule

FILE: rtl/tsf_seg_track.sv
module tsf_seg_track (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tsf_pkg::t_seg_ctl         i_ctl,
    input  logic [7:0]                i_byte,
    input  logic [tsf_pkg::PatW-1:0]  i_plen,
    input  logic                      i_hit,
    output logic                      o_take,
    output tsf_pkg::t_out_word        o_result
);
    import tsf_pkg::*;

    logic [PosW-1:0] r_pos;
    logic [PosW-1:0] n_pos;
    logic            r_match;
    logic            n_match;
    logic [7:0]      r_hdr [4];
    logic [7:0]      n_hdr [4];
    t_verdict        verdict;

    assign o_take = i_ctl.seg && (r_pos < PosW'(MaxBytes));

    always_comb begin
        n_pos = o_take ? (r_pos + PosW'(1)) : r_pos;
        for (int h = 0; h < 4; h++) begin
            n_hdr[h] = r_hdr[h];
        end
        if (o_take) begin
            if (r_pos == PosW'(0)) n_hdr[0] = i_byte;
            if (r_pos == PosW'(1)) n_hdr[1] = i_byte;
            if (r_pos == PosW'(2)) n_hdr[2] = i_byte;
            if (r_pos == PosW'(5)) n_hdr[3] = i_byte;
        end
        n_match = r_match ||
                  (o_take && i_hit &&
                   (n_pos >= (PosW'(MatchStart) + PosW'(i_plen))));
    end

    always_comb begin
        priority if (n_pos < PosW'(MinSegment)) begin
            verdict = VerdictShort;
        end else if (n_hdr[0] != RecHandshake) begin
            verdict = VerdictNotTls;
        end else if ((n_hdr[1] < VerMajor) ||
                     ((n_hdr[1] == VerMajor) && (n_hdr[2] < VerMinor))) begin
            verdict = VerdictOldVer;
        end else if (n_hdr[3] != HsClientHello) begin
            verdict = VerdictNotHello;
        end else if (n_match) begin
            verdict = VerdictAccept;
        end else begin
            verdict = VerdictNoMatch;
        end
    end

    assign o_result.verdict         = verdict;
    assign o_result.accepted_length = (verdict == VerdictAccept) ? n_pos : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_match <= 1'b0;
            for (int h = 0; h < 4; h++) begin
                r_hdr[h] <= '0;
            end
        end else if (i_ctl.seg && i_ctl.last) begin
            r_pos   <= '0;
            r_match <= 1'b0;
            for (int h = 0; h < 4; h++) begin
                r_hdr[h] <= '0;
            end
        end else if (o_take) begin
            r_pos   <= n_pos;
            r_match <= n_match;
            for (int h = 0; h < 4; h++) begin
                r_hdr[h] <= n_hdr[h];
            end
        end
    end

endmodule

FILE: tb/tb_tls_hello_sni_filter_unit.sv
module tb_tls_hello_sni_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tsf_pkg::*;

    // run shape
    localparam int IdlePct      = 12;    // idle / stall chance per cycle, percent
    localparam int SettleCycles = 4;     // pipeline is two deep; margin before a cfg write
    localparam int TailCycles   = 8;     // quiet cycles after the last verdict
    localparam int RandWords    = 500;   // random stimulus words, at least
    localparam int RandVerdicts = 8;     // random verdicts, at least
    localparam int NumRows      = 19;
    localparam int NoCfg        = -1;    // row leaves pattern_len alone
    localparam int NoEmbed      = -1;    // row carries no pattern copy
    localparam int MaxReports   = 10;

    // ------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------
    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [PatW-1:0] cfg_data;

    always #5 clk = ~clk;

    tls_hello_sni_filter_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // filter predictor: own copy of pattern, window, counters, pattern_len
    // ------------------------------------------------------------------
    logic [7:0]      sni_pat [MaxPattern];
    logic [7:0]      sni_win [MaxPattern];   // [0] is the newest byte
    logic [7:0]      sni_hdr [4];            // segment bytes 0, 1, 2 and 5
    int              sni_pos;
    bit              sni_hit;
    logic [PatW-1:0] sni_plen;

    t_out_word  verdict_q [$];               // verdicts still owed by the DUT
    logic [7:0] seg_bytes [$];               // segment being streamed

    int  words_sent;
    int  verdicts_owed;                      // verdicts predicted so far
    int  mismatch_count;
    bit  calm;                               // no idling on either side

    function automatic int eff_len();
        int n;
        n = int'(sni_plen);
        if (n < MinPattern) n = MinPattern;
        if (n > MaxPattern) n = MaxPattern;
        return n;
    endfunction

    function automatic void seg_clear();
        for (int k = 0; k < MaxPattern; k++) sni_win[k] = 8'h00;
        for (int k = 0; k < 4; k++) sni_hdr[k] = 8'h00;
        sni_pos = 0;
        sni_hit = 1'b0;
    endfunction

    function automatic bit window_hit(input int n);
        for (int k = 0; k < n; k++)
            if (sni_win[k] != sni_pat[n-1-k]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void take_seg_byte(input logic [7:0] b);
        int n;
        n = eff_len();
        if (sni_pos >= MaxBytes) return;           // overflow bytes are dropped
        case (sni_pos)
            0: sni_hdr[0] = b;
            1: sni_hdr[1] = b;
            2: sni_hdr[2] = b;
            5: sni_hdr[3] = b;
            default: ;
        endcase
        for (int k = MaxPattern - 1; k > 0; k--) sni_win[k] = sni_win[k-1];
        sni_win[0] = b;
        sni_pos++;
        // whole pattern received and starting at offset 32 or later
        if (sni_pos >= MatchStart + n && window_hit(n)) sni_hit = 1'b1;
    endfunction

    function automatic t_verdict judge_segment();
        if (sni_pos < MinSegment) return VerdictShort;
        if (sni_hdr[0] != RecHandshake) return VerdictNotTls;
        if (sni_hdr[1] < VerMajor || (sni_hdr[1] == VerMajor && sni_hdr[2] < VerMinor))
            return VerdictOldVer;
        if (sni_hdr[3] != HsClientHello) return VerdictNotHello;
        if (sni_hit) return VerdictAccept;
        return VerdictNoMatch;
    endfunction

    function automatic void sni_predict(input t_in_word w, output bit has_res,
                                        output t_out_word res);
        t_verdict v;
        has_res = 1'b0;
        res     = '0;
        if (w.cmd == CmdPattern) begin
            // last_byte means nothing on a pattern write; index 127 is dropped
            if (w.pattern_index < MaxPattern) sni_pat[w.pattern_index] = w.byte_value;
            return;
        end
        take_seg_byte(w.byte_value);
        if (!w.last_byte) return;
        v = judge_segment();
        has_res             = 1'b1;
        res.verdict         = v;
        res.accepted_length = (v == VerdictAccept) ? sni_pos[PosW-1:0] : '0;
        seg_clear();
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // Offer one word, hold it through stalls, predict on the accepting edge.
    // A typed verdict, when given, replaces the predicted one.
    task automatic send_word(input t_in_word w, input bit use_typed,
                             input t_out_word typed_res);
        bit        has_res;
        t_out_word res;
        while (!calm && $urandom_range(0, 99) < IdlePct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sni_predict(w, has_res, res);
        if (has_res) begin
            verdict_q.push_back(use_typed ? typed_res : res);
            verdicts_owed++;
        end
        words_sent++;
    endtask

    task automatic write_pattern(input logic [IdxW-1:0] idx, input logic [7:0] b);
        t_in_word w;
        w.cmd           = CmdPattern;
        w.pattern_index = idx;
        w.byte_value    = b;
        w.last_byte     = 1'($urandom_range(0, 1));
        send_word(w, 1'b0, '0);
    endtask

    // pattern_len only changes with the block idle: queue drained, pipe settled
    task automatic write_pattern_len(input int v);
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v[PatW-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sni_plen = v[PatW-1:0];
    endtask

    // Fill seg_bytes: random body, header bytes placed, pattern copied in at
    // offset 'at' (clipped at the segment end).
    function automatic void build_segment(input int len, input int rec, input int vmaj,
                                          input int vmin, input int hs, input int at);
        int n;
        n = eff_len();
        seg_bytes.delete();
        for (int i = 0; i < len; i++) seg_bytes.push_back(8'($urandom_range(0, 255)));
        if (len > 0) seg_bytes[0] = rec[7:0];
        if (len > 1) seg_bytes[1] = vmaj[7:0];
        if (len > 2) seg_bytes[2] = vmin[7:0];
        if (len > 5) seg_bytes[5] = hs[7:0];
        if (at >= 0)
            for (int k = 0; k < n; k++)
                if (at + k < len) seg_bytes[at+k] = sni_pat[k];
    endfunction

    // Stream seg_bytes as segment words. noise_pct > 0 mixes in pattern
    // writes and stray last_byte marks that cut the segment short.
    task automatic stream_segment(input int noise_pct, input bit use_typed,
                                  input t_out_word typed_res);
        t_in_word w;
        int       len;
        len = seg_bytes.size();
        for (int i = 0; i < len; i++) begin
            if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct)
                write_pattern(IdxW'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
            w.cmd           = CmdSegment;
            w.pattern_index = IdxW'($urandom_range(0, 127));   // don't care here
            w.byte_value    = seg_bytes[i];
            w.last_byte     = (i == len - 1) ||
                              (noise_pct > 0 && $urandom_range(0, 99) < 3);
            send_word(w, use_typed && (i == len - 1), typed_res);
        end
    endtask

    function automatic int pick_pattern_len();
        case ($urandom_range(0, 9))
            0: return 0;                          // acts as 4
            1: return 3;                          // acts as 4
            2: return MaxPattern;
            3: return int'($urandom_range(MinPattern, MaxPattern));
            default: return int'($urandom_range(MinPattern, 12));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // output side: stall at random, check every accepted verdict word
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (verdict_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MaxReports)
                    $display("%0t: verdict word with none owed: verdict %0d length %0d",
                             $realtime, out_word.verdict, out_word.accepted_length);
            end else begin
                want = verdict_q.pop_front();
                if (out_word.verdict !== want.verdict ||
                    out_word.accepted_length !== want.accepted_length) begin
                    mismatch_count++;
                    if (mismatch_count <= MaxReports)
                        $display("%0t: verdict exp %0d got %0d, length exp %0d got %0d",
                                 $realtime, want.verdict, out_word.verdict,
                                 want.accepted_length, out_word.accepted_length);
                end
            end
        end
        out_stall <= !calm && ($urandom_range(0, 99) < IdlePct);
    end

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    typedef struct packed {
        int       cfg;        // pattern_len written before the row, or NoCfg
        int       len;        // segment length
        int       rec;        // byte 0
        int       vmaj;       // byte 1
        int       vmin;       // byte 2
        int       hs;         // byte 5
        int       at;         // pattern offset, or NoEmbed
        bit       typed;      // verdict below is typed in, else predicted
        t_verdict ev;
        int       el;
    } t_row;

    t_row rows [NumRows];

    initial begin
        t_out_word typed_res;
        int        r;
        int        n;
        int        len;
        int        at;
        int        rec;
        int        vmaj;
        int        vmin;
        int        hs;
        int        noise;
        int        rand_words0;
        int        rand_verdicts0;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        calm           = 1'b0;
        words_sent     = 0;
        verdicts_owed  = 0;
        mismatch_count = 0;
        sni_plen       = PatW'(MinPattern);
        for (int k = 0; k < MaxPattern; k++) sni_pat[k] = 8'h00;
        seg_clear();

        rows = '{
            // after reset: one-byte segment
            '{MinPattern, 1, 'h16, 3, 1, 1, NoEmbed, 1'b1, VerdictShort, 0},
            // one byte short, match present: short wins
            '{NoCfg, 42, 'h16, 3, 1, 1, 32, 1'b1, VerdictShort, 0},
            '{NoCfg, 10, 'h00, 0, 0, 0, NoEmbed, 1'b1, VerdictShort, 0},
            // header faults in priority order, pattern present each time
            '{NoCfg, 43, 'h17, 3, 1, 1, 32, 1'b1, VerdictNotTls, 0},
            '{NoCfg, 43, 'h16, 2, 'hFF, 1, 32, 1'b1, VerdictOldVer, 0},
            '{NoCfg, 43, 'h16, 3, 0, 1, 32, 1'b1, VerdictOldVer, 0},
            '{NoCfg, 43, 'h16, 3, 1, 2, 32, 1'b1, VerdictNotHello, 0},
            // minimum accept: shortest segment, earliest offset
            '{NoCfg, 43, 'h16, 3, 1, 1, 32, 1'b1, VerdictAccept, 43},
            // major 0xFF compares unsigned; pattern ends on the last byte
            '{NoCfg, 60, 'h16, 'hFF, 'h00, 1, 56, 1'b1, VerdictAccept, 60},
            // one offset too early, running past the end, absent
            '{NoCfg, 60, 'h16, 3, 1, 1, 31, 1'b0, VerdictNoMatch, 0},
            '{NoCfg, 60, 'h16, 3, 1, 1, 58, 1'b0, VerdictNoMatch, 0},
            '{NoCfg, 60, 'h16, 3, 1, 1, NoEmbed, 1'b0, VerdictNoMatch, 0},
            // lengths below the minimum act as four
            '{0, 60, 'h16, 3, 1, 1, 40, 1'b1, VerdictAccept, 60},
            '{3, 50, 'h16, 3, 1, 1, 46, 1'b1, VerdictAccept, 50},
            // longest pattern
            '{MaxPattern, 160, 'h16, 3, 3, 1, 32, 1'b1, VerdictAccept, 160},
            '{NoCfg, 160, 'h16, 3, 3, 1, 31, 1'b0, VerdictNoMatch, 0},
            '{NoCfg, 158, 'h16, 3, 3, 1, 32, 1'b0, VerdictNoMatch, 0},
            // past the byte limit: match ends on the last counted byte,
            // count saturates, late bytes ignored
            '{1, 1026, 'h16, 3, 1, 1, 1020, 1'b1, VerdictAccept, MaxBytes},
            '{5, 43, 'h16, 3, 1, 0, 32, 1'b1, VerdictNotHello, 0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every pattern entry gets a value before any window compare reads it,
        // plus one write at the out-of-range index
        for (int i = 0; i < MaxPattern; i++)
            write_pattern(IdxW'(i), 8'($urandom_range(0, 255)));
        write_pattern({IdxW{1'b1}}, 8'($urandom_range(0, 255)));

        for (int i = 0; i < NumRows; i++) begin
            if (rows[i].cfg != NoCfg) write_pattern_len(rows[i].cfg);
            build_segment(rows[i].len, rows[i].rec, rows[i].vmaj, rows[i].vmin,
                          rows[i].hs, rows[i].at);
            typed_res.verdict         = rows[i].ev;
            typed_res.accepted_length = rows[i].el[PosW-1:0];
            stream_segment(0, rows[i].typed, typed_res);
        end

        // random part: mostly well-formed hellos with the pattern somewhere
        // legal, the rest header faults, near misses and noise
        rand_words0    = words_sent;
        rand_verdicts0 = verdicts_owed;
        while (words_sent - rand_words0 < RandWords ||
               verdicts_owed - rand_verdicts0 < RandVerdicts) begin
            // one long stretch with no idling on either side
            calm = (words_sent - rand_words0 >= 150) && (words_sent - rand_words0 < 350);

            if ($urandom_range(0, 99) < 8) write_pattern_len(pick_pattern_len());
            if ($urandom_range(0, 99) < 10)
                repeat ($urandom_range(1, 6))
                    write_pattern(IdxW'($urandom_range(0, 127)),
                                  8'($urandom_range(0, 255)));

            n     = eff_len();
            rec   = int'(RecHandshake);
            hs    = int'(HsClientHello);
            vmaj  = int'(VerMajor);
            vmin  = int'($urandom_range(1, 4));
            noise = ($urandom_range(0, 99) < 5) ? 2 : 0;
            if ($urandom_range(0, 4) == 0) begin
                vmaj = int'($urandom_range(4, 255));
                vmin = int'($urandom_range(0, 255));
            end
            len = MatchStart + n + int'($urandom_range(0, 24));
            at  = int'($urandom_range(MatchStart, len - n));

            r = int'($urandom_range(0, 99));
            if (r < 65) begin
                // well-formed, pattern in place
            end else if (r < 75) begin
                // near misses around the match window
                case ($urandom_range(0, 2))
                    0: at = MatchStart - 1;
                    1: at = len - n + int'($urandom_range(1, n - 1));
                    default: at = NoEmbed;
                endcase
            end else if (r < 90) begin
                case ($urandom_range(0, 3))
                    0: rec  = int'($urandom_range(0, 255));
                    1: vmaj = int'($urandom_range(0, 2));
                    2: begin
                        vmaj = int'(VerMajor);
                        vmin = 0;
                    end
                    default: hs = int'($urandom_range(0, 255));
                endcase
                if ($urandom_range(0, 3) == 0)
                    len = int'($urandom_range(MinSegment - 3, MinSegment));
            end else begin
                // junk: random header, random length, interleaved writes
                len   = int'($urandom_range(1, 60));
                rec   = ($urandom_range(0, 1) != 0) ? int'(RecHandshake)
                                                    : int'($urandom_range(0, 255));
                vmaj  = int'($urandom_range(0, 255));
                vmin  = int'($urandom_range(0, 255));
                hs    = int'($urandom_range(0, 255));
                at    = (len > MatchStart + n) ? int'($urandom_range(MatchStart, len - n))
                                               : NoEmbed;
                noise = 15;
            end
            build_segment(len, rec, vmaj, vmin, hs, at);
            stream_segment(noise, 1'b0, '0);
        end
        calm = 1'b0;

        // drain, then a few quiet cycles to catch stray verdict words
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (TailCycles) @(posedge clk);

        if (mismatch_count == 0 && verdict_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tsf_pkg.sv
rtl/tsf_matcher.sv
rtl/tsf_seg_track.sv
rtl/tls_hello_sni_filter_unit.sv
tb/tb_tls_hello_sni_filter_unit.sv
